@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the LED strip fireworks checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define LFB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define LFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lfb_pkg.sv @@
// ----------------------------------------------------------------------------
// lfb_pkg
// Types, register codes and per-channel arithmetic for the fireworks
// fade and blur effect.
// ----------------------------------------------------------------------------
package lfb_pkg;

    localparam int CH_W       = 8;
    localparam int POS_W      = 6;
    localparam int CNT_W      = 7;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 2 * CH_W;

    // Faded values below this threshold drop to two thirds
    localparam int FADE_LOW       = 64;
    // 2/3 as 342/512, exact for values below the threshold
    localparam int TWO_THIRDS_MUL = 342;
    localparam int TWO_THIRDS_SH  = 9;

    // Register reset values
    localparam logic [CH_W-1:0]   RST_FADE_RATE  = 8'd0;
    localparam logic [TICK_W-1:0] RST_INTERVAL   = 16'd32;
    localparam logic              RST_USE_RANDOM = 1'b1;
    localparam logic [CH_W-1:0]   RST_BASE       = 8'd255;
    localparam logic [CNT_W-1:0]  RST_LED_COUNT  = 7'd64;
    localparam logic [CNT_W-1:0]  MIN_LED_COUNT  = 7'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FADE_OUT_RATE    = 3'd0,
        REG_UPDATE_INTERVAL  = 3'd1,
        REG_USE_RANDOM_COLOR = 3'd2,
        REG_BASE_RED         = 3'd3,
        REG_BASE_GREEN       = 3'd4,
        REG_BASE_BLUE        = 3'd5,
        REG_LED_COUNT        = 3'd6
    } cfg_reg_t;

    // One pixel, element 0 red, 1 green, 2 blue
    typedef logic [2:0][CH_W-1:0] rgb_t;

    typedef struct packed {
        logic             spark_request;
        logic [POS_W-1:0] spark_position;
        logic [CH_W-1:0]  spark_red;
        logic [CH_W-1:0]  spark_green;
        logic [CH_W-1:0]  spark_blue;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0] pixel_index;
        logic [CH_W-1:0]  pixel_red;
        logic [CH_W-1:0]  pixel_green;
        logic [CH_W-1:0]  pixel_blue;
        logic             last_pixel;
    } out_item_t;

    // Divide a channel product by 255, then take two thirds of small results
    function automatic logic [CH_W-1:0] fade_fix(input logic [PROD_W-1:0] prod);
        logic [PROD_W:0]   q_sum;
        logic [CH_W-1:0]   q;
        logic [PROD_W-1:0] t;
        q_sum = {1'b0, prod} + (PROD_W+1)'(prod[PROD_W-1:CH_W]) + (PROD_W+1)'(1);
        q     = q_sum[PROD_W-1:CH_W];
        t     = PROD_W'(q[5:0]) * PROD_W'(TWO_THIRDS_MUL);
        if (q < CH_W'(FADE_LOW))
        begin
            return CH_W'(t >> TWO_THIRDS_SH);
        end
        return q;
    endfunction

    // Blur one channel with saturation at full scale
    function automatic logic [CH_W-1:0] blur_ch(
        input logic [CH_W-1:0] prev,
        input logic [CH_W-1:0] cur,
        input logic [CH_W-1:0] nxt,
        input logic            is_first,
        input logic            is_last
    );
        logic [CH_W+1:0] s;
        if (is_first)
        begin
            s = (CH_W+2)'(cur) + (CH_W+2)'(nxt >> 1);
        end
        else if (is_last)
        begin
            s = (CH_W+2)'(cur) + (CH_W+2)'(prev >> 1);
        end
        else
        begin
            s = (CH_W+2)'(prev >> 2) + (CH_W+2)'(cur) + (CH_W+2)'(nxt >> 2);
        end
        return (s[CH_W+1:CH_W] != 2'b00) ? {CH_W{1'b1}} : s[CH_W-1:0];
    endfunction

endpackage

@@ design/lfb_ram.sv @@
// ----------------------------------------------------------------------------
// lfb_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module lfb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ design/led_strip_fireworks_fade_blur.sv @@
// Tick without a frame: accepted while idle, no pixels out.
// Frame tick: each pixel in use costs one memory read, four steps on the
// shared 8x8 multiplier (three channels, one per cycle) and a blur and
// write-back step that waits while the pixel output is stalled. Ticks are
// not taken meanwhile.
// Reset: registers to defaults, pixel store black via per-entry valid bits.
// ----------------------------------------------------------------------------
// led_strip_fireworks_fade_blur
// Fireworks effect for an RGB strip: tick counter, per-frame fade and
// in-place blur walk, optional spark, and one output transfer per pixel.
// ----------------------------------------------------------------------------
module led_strip_fireworks_fade_blur #(
    parameter int MAX_LEDS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // tick channel
    input  logic                             tick_valid,
    output logic                             tick_ready,
    input  lfb_pkg::in_item_t                tick,
    // pixel channel
    output logic                             pixel_valid,
    input  logic                             pixel_ready,
    output lfb_pkg::out_item_t               pixel,
    // configuration channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lfb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CNT_W = lfb_pkg::CNT_W;
    localparam int CH_W  = lfb_pkg::CH_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_FADE = 4'b0100,
        ST_BLUR = 4'b1000
    } state_t;

    // Control state
    state_t                       state_reg, state_next;
    logic [lfb_pkg::TICK_W-1:0]   tick_cnt_reg, tick_cnt_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [AW-1:0]                rd_addr_reg, rd_addr_next;
    logic [1:0]                   step_reg, step_next;
    logic                         prime_reg, prime_next;
    logic                         out_valid_reg, out_valid_next;
    logic [MAX_LEDS-1:0]          written_reg, written_next;
    logic                         rd_written_reg;

    // Configuration registers
    logic [CH_W-1:0]              fade_rate_reg, fade_rate_next;
    logic [lfb_pkg::TICK_W-1:0]   interval_reg, interval_next;
    logic                         use_random_reg, use_random_next;
    logic [CH_W-1:0]              base_red_reg, base_red_next;
    logic [CH_W-1:0]              base_green_reg, base_green_next;
    logic [CH_W-1:0]              base_blue_reg, base_blue_next;
    logic [CNT_W-1:0]             led_count_reg, led_count_next;

    // Datapath registers
    lfb_pkg::in_item_t            spark_reg, spark_next;
    lfb_pkg::out_item_t           out_reg, out_next;
    lfb_pkg::rgb_t                prev_reg, prev_next;
    lfb_pkg::rgb_t                cur_reg, cur_next;
    lfb_pkg::rgb_t                nxt_reg, nxt_next;
    logic [lfb_pkg::PROD_W-1:0]   prod_reg, prod_next;

    // Combinational signals
    logic [lfb_pkg::TICK_W-1:0]   tick_inc;
    logic [CNT_W-1:0]             n_use;
    logic [CNT_W-1:0]             last_w;
    logic [AW-1:0]                last_idx;
    logic [CNT_W-1:0]             idx_w;
    logic [CH_W-1:0]              mult;
    logic [CH_W-1:0]              mul_in;
    logic [23:0]                  ram_rdata;
    lfb_pkg::rgb_t                rd_pix;
    lfb_pkg::rgb_t                blurred;
    lfb_pkg::rgb_t                spark_pix;
    lfb_pkg::rgb_t                final_pix;
    logic                         is_first;
    logic                         is_last;
    logic                         spark_hit;
    logic                         out_free;
    logic                         emit;
    logic                         tick_xfer;
    logic                         cfg_xfer;

    // Pixel store
    lfb_ram #(
        .WIDTH ($bits(lfb_pkg::rgb_t)),
        .DEPTH (MAX_LEDS)
    ) u_store (
        .clk   (clk),
        .we    (emit),
        .waddr (idx_reg),
        .wdata (final_pix),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Handshake outputs
    assign tick_ready  = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign pixel_valid = out_valid_reg;
    assign pixel       = out_reg;
    assign tick_xfer   = tick_valid && tick_ready;
    assign cfg_xfer    = cfg_valid && cfg_ready;

    // Clamp the pixel count in use
    always_comb
    begin
        if (led_count_reg < lfb_pkg::MIN_LED_COUNT)
        begin
            n_use = lfb_pkg::MIN_LED_COUNT;
        end
        else if (led_count_reg > CNT_W'(MAX_LEDS))
        begin
            n_use = CNT_W'(MAX_LEDS);
        end
        else
        begin
            n_use = led_count_reg;
        end
    end

    assign last_w   = n_use - CNT_W'(1);
    assign last_idx = last_w[AW-1:0];
    assign idx_w    = CNT_W'(idx_reg);
    assign tick_inc = tick_cnt_reg + lfb_pkg::TICK_W'(1);
    assign mult     = 8'd255 - fade_rate_reg;

    // Unwritten entries read as black
    assign rd_pix = rd_written_reg ? lfb_pkg::rgb_t'(ram_rdata) : '0;

    // Shared multiplier operand: one channel per step
    always_comb
    begin
        case (step_reg)
            2'd0:    mul_in = rd_pix[0];
            2'd1:    mul_in = rd_pix[1];
            2'd2:    mul_in = rd_pix[2];
            default: mul_in = '0;
        endcase
    end

    // Blur and spark for the pixel at the walk position
    assign is_first  = (idx_reg == '0);
    assign is_last   = (idx_reg == last_idx);
    assign spark_hit = spark_reg.spark_request &&
                       (CNT_W'(spark_reg.spark_position) == idx_w);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            blurred[c] = lfb_pkg::blur_ch(prev_reg[c], cur_reg[c], nxt_reg[c],
                                          is_first, is_last);
        end
        if (use_random_reg)
        begin
            spark_pix[0] = spark_reg.spark_red;
            spark_pix[1] = spark_reg.spark_green;
            spark_pix[2] = spark_reg.spark_blue;
        end
        else
        begin
            spark_pix[0] = base_red_reg;
            spark_pix[1] = base_green_reg;
            spark_pix[2] = base_blue_reg;
        end
        final_pix = spark_hit ? spark_pix : blurred;
    end

    assign out_free = !out_valid_reg || pixel_ready;
    assign emit     = (state_reg == ST_BLUR) && !prime_reg && out_free;

    // Sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        tick_cnt_next  = tick_cnt_reg;
        idx_next       = idx_reg;
        rd_addr_next   = rd_addr_reg;
        step_next      = step_reg;
        prime_next     = prime_reg;
        written_next   = written_reg;
        spark_next     = spark_reg;
        out_next       = out_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;

        // Drop the output once it is taken
        if (pixel_valid && pixel_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (tick_xfer)
                begin
                    if (tick_inc < interval_reg)
                    begin
                        tick_cnt_next = tick_inc;
                    end
                    else
                    begin
                        tick_cnt_next = '0;
                        spark_next    = tick;
                        idx_next      = '0;
                        rd_addr_next  = '0;
                        prime_next    = 1'b1;
                        state_next    = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                step_next  = '0;
                state_next = ST_FADE;
            end
            ST_FADE:
            begin
                // Multiply one channel, correct the previous product
                if (step_reg != 2'd3)
                begin
                    prod_next = lfb_pkg::PROD_W'(mul_in) * lfb_pkg::PROD_W'(mult);
                end
                if (step_reg != 2'd0)
                begin
                    nxt_next[step_reg - 2'd1] = lfb_pkg::fade_fix(prod_reg);
                end
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    state_next = ST_BLUR;
                end
            end
            ST_BLUR:
            begin
                if (prime_reg)
                begin
                    // Pixel 0 is faded: move it to current and fetch pixel 1
                    cur_next     = nxt_reg;
                    prime_next   = 1'b0;
                    rd_addr_next = AW'(1);
                    state_next   = ST_READ;
                end
                else if (out_free)
                begin
                    out_next.pixel_index = lfb_pkg::POS_W'(idx_reg);
                    out_next.pixel_red   = final_pix[0];
                    out_next.pixel_green = final_pix[1];
                    out_next.pixel_blue  = final_pix[2];
                    out_next.last_pixel  = is_last;
                    out_valid_next       = 1'b1;
                    written_next[idx_reg] = 1'b1;
                    prev_next            = blurred;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                        cur_next = nxt_reg;
                        if ((idx_w + CNT_W'(1)) < last_w)
                        begin
                            rd_addr_next = AW'(idx_w + CNT_W'(2));
                            state_next   = ST_READ;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_comb
    begin
        fade_rate_next  = fade_rate_reg;
        interval_next   = interval_reg;
        use_random_next = use_random_reg;
        base_red_next   = base_red_reg;
        base_green_next = base_green_reg;
        base_blue_next  = base_blue_reg;
        led_count_next  = led_count_reg;
        if (cfg_xfer)
        begin
            case (lfb_pkg::cfg_reg_t'(cfg_index))
                lfb_pkg::REG_FADE_OUT_RATE:    fade_rate_next  = cfg_data[CH_W-1:0];
                lfb_pkg::REG_UPDATE_INTERVAL:  interval_next   = cfg_data;
                lfb_pkg::REG_USE_RANDOM_COLOR: use_random_next = cfg_data[0];
                lfb_pkg::REG_BASE_RED:         base_red_next   = cfg_data[CH_W-1:0];
                lfb_pkg::REG_BASE_GREEN:       base_green_next = cfg_data[CH_W-1:0];
                lfb_pkg::REG_BASE_BLUE:        base_blue_next  = cfg_data[CH_W-1:0];
                lfb_pkg::REG_LED_COUNT:        led_count_next  = cfg_data[CNT_W-1:0];
                default:                       ;
            endcase
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tick_cnt_reg   <= '0;
            idx_reg        <= '0;
            rd_addr_reg    <= '0;
            step_reg       <= '0;
            prime_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            fade_rate_reg  <= lfb_pkg::RST_FADE_RATE;
            interval_reg   <= lfb_pkg::RST_INTERVAL;
            use_random_reg <= lfb_pkg::RST_USE_RANDOM;
            base_red_reg   <= lfb_pkg::RST_BASE;
            base_green_reg <= lfb_pkg::RST_BASE;
            base_blue_reg  <= lfb_pkg::RST_BASE;
            led_count_reg  <= lfb_pkg::RST_LED_COUNT;
        end
        else
        begin
            state_reg      <= state_next;
            tick_cnt_reg   <= tick_cnt_next;
            idx_reg        <= idx_next;
            rd_addr_reg    <= rd_addr_next;
            step_reg       <= step_next;
            prime_reg      <= prime_next;
            out_valid_reg  <= out_valid_next;
            written_reg    <= written_next;
            rd_written_reg <= written_reg[rd_addr_reg];
            fade_rate_reg  <= fade_rate_next;
            interval_reg   <= interval_next;
            use_random_reg <= use_random_next;
            base_red_reg   <= base_red_next;
            base_green_reg <= base_green_next;
            base_blue_reg  <= base_blue_next;
            led_count_reg  <= led_count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        spark_reg <= spark_next;
        out_reg   <= out_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        nxt_reg   <= nxt_next;
        prod_reg  <= prod_next;
    end

endmodule

@@ design/lfb_checker.sv @@
// ----------------------------------------------------------------------------
// lfb_checker
// Port-level checks on the fireworks block: output hold, pixel order,
// frame end and tick acceptance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           tick_valid,
    input logic                           tick_ready,
    input logic                           pixel_valid,
    input logic                           pixel_ready,
    input lfb_pkg::out_item_t             pixel
);

    logic [lfb_pkg::POS_W-1:0] exp_idx_reg;
    logic                      pix_xfer;

    assign pix_xfer = pixel_valid && pixel_ready;

    // Track the index the next pixel transfer must carry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
        end
        else if (pix_xfer)
        begin
            exp_idx_reg <= pixel.last_pixel ? '0 : exp_idx_reg + lfb_pkg::POS_W'(1);
        end
    end

    `LFB_ASSERT_NEXT(a_pixel_hold, clk, rst_n, pixel_valid && !pixel_ready, pixel_valid && $stable(pixel), "pixel dropped or changed while stalled")
    `LFB_ASSERT_IMPL(a_pixel_order, clk, rst_n, pix_xfer, pixel.pixel_index == exp_idx_reg, "pixel transfer out of index order")
    `LFB_ASSERT_IMPL(a_frame_len, clk, rst_n, pix_xfer && pixel.last_pixel, pixel.pixel_index != '0, "frame ended after a single pixel")
    `LFB_ASSERT_IMPL(a_busy_start, clk, rst_n, $fell(tick_ready), $past(tick_valid && tick_ready), "tick channel went busy without a tick transfer")

endmodule

bind led_strip_fireworks_fade_blur lfb_checker u_lfb_checker (.*);
